// File: hw/rtl/hsmb_pkg.sv
// Shared constants, types and the cosine table of the Hann smoothing block.
package hsmb_pkg;

	localparam int MAX_WINDOW = 63;
	localparam int MAX_LENGTH = 1048576;
	localparam int COS_TABLE_DEPTH = 256;
	localparam int HIST_DEPTH = 64;

	localparam int SAMPLE_W = 32;
	localparam int POS_W = 21;
	localparam int WIN_W = 6;
	localparam int COEF_W = 16;
	localparam int SMOOTH_W = 48;
	localparam int ACC_W = 54;
	localparam int MAX_MINIMA = 3;

	localparam logic [POS_W-1:0] MAX_LENGTH_P = POS_W'(MAX_LENGTH);

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
	localparam longint unsigned Q30_ONE = 64'd1073741824;

	typedef logic signed [16:0] cos_tab_t [COS_TABLE_DEPTH];

	// Exact unsigned quotient by shift and subtract; only used to build constants.
	function automatic longint unsigned udiv_const(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// cos(pi/2 * u / D) in Q15 from a truncated Taylor series in Q30.
	function automatic int quarter_cos(input longint unsigned u);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x = (PI_HALF_Q30 * u) / COS_TABLE_DEPTH;
		x2 = (x * x) >> 30;
		term = Q30_ONE;
		sum = longint'(Q30_ONE);
		for (int k = 1; k <= 7; k++) begin
			term = udiv_const((term * x2) >> 30, longint'((2 * k - 1) * (2 * k)));
			if ((k % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(Q30_ONE)) begin
			sum = longint'(Q30_ONE);
		end
		return int'((sum + 16384) >>> 15);
	endfunction

	function automatic cos_tab_t build_cos_tab();
		cos_tab_t tab;
		longint unsigned a;
		longint unsigned q;
		longint unsigned r;
		int v;
		for (int j = 0; j < COS_TABLE_DEPTH; j++) begin
			a = 4 * longint'(j);
			q = (a / COS_TABLE_DEPTH) & 3;
			r = a % COS_TABLE_DEPTH;
			case (q)
				0: v = quarter_cos(r);
				1: v = -quarter_cos(COS_TABLE_DEPTH - r);
				2: v = -quarter_cos(r);
				default: v = quarter_cos(COS_TABLE_DEPTH - r);
			endcase
			tab[j] = 17'(v);
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_TAB = build_cos_tab();

	// Hann coefficient in Q1.15 for one cosine table index.
	function automatic logic [COEF_W-1:0] hann_coef(input logic [7:0] idx);
		int c;
		c = int'(COS_TAB[idx]);
		return COEF_W'((32768 - c + 1) >>> 1);
	endfunction

	// Effective odd window length in 3..MAX_WINDOW.
	function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
		logic [WIN_W-1:0] e;
		e = w;
		if (int'(e) > MAX_WINDOW) begin
			e = WIN_W'(MAX_WINDOW);
		end
		if (!e[0] && e != '0) begin
			e = e - WIN_W'(1);
		end
		if (e < WIN_W'(3)) begin
			e = WIN_W'(3);
		end
		return e;
	endfunction

endpackage

// File: hw/rtl/hsmb_if.sv
// Stream interfaces for samples in and segments out.
interface hsmb_sample_if;
	logic valid;
	logic ready;
	logic signed [31:0] sample;
	logic is_final;
	modport source(output valid, sample, is_final, input ready);
	modport sink(input valid, sample, is_final, output ready);
endinterface

interface hsmb_block_if;
	logic valid;
	logic ready;
	logic [20:0] block_start;
	logic [20:0] block_end;
	logic final_block;
	modport source(output valid, block_start, block_end, final_block, input ready);
	modport sink(input valid, block_start, block_end, final_block, output ready);
endinterface

// File: hw/rtl/hann_smoothing_minima_blocker.sv
// Hann smoothing of a sample stream and segmentation at local minima.
//
//   channel   dir   handshake      payload
//   samples   in    valid/ready    sample (s32 Q16.16), is_final
//   blocks    out   valid/ready    block_start, block_end, final_block
//   APB       in    psel/penable   window_length at byte address 0
//
// After reset and after every window write the coefficients are rebuilt, one tap
// at a time, while samples are not taken.
// A smoothed sample is accepted, passes through the shared multiplier and the two
// memory read ports, and is then checked for a minimum. A position before the smoothed
// range is checked with a zero value; a sample inside the leading margin or past the
// length limit is taken without a check. A final sample adds the trailing positions and
// the closing transfer. A full output register holds the block until the transfer
// completes, and a new block waits for it.
module hann_smoothing_minima_blocker (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	hsmb_sample_if.sink samples,
	hsmb_block_if.source blocks
);

	typedef enum logic [5:0] {
		ST_BUILD = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_MAC   = 6'b000100,
		ST_PUSH  = 6'b001000,
		ST_FLUSH = 6'b010000,
		ST_CLOSE = 6'b100000
	} state_t;

	localparam int PW = hsmb_pkg::POS_W;
	localparam int WW = hsmb_pkg::WIN_W;
	localparam int SW = hsmb_pkg::SMOOTH_W;

	state_t state_q;

	logic [WW-1:0] cfg_q;
	logic [WW-1:0] win_q;
	logic [PW-1:0] count_q;
	logic [PW-1:0] seg_start_q;
	logic [PW-1:0] pos_q;
	logic signed [SW-1:0] prev_q;
	logic signed [SW-1:0] prev2_q;
	logic signed [SW-1:0] val_q;
	logic [1:0] nres_q;
	logic fin_q;
	logic flush_q;

	// Coefficient builder.
	logic [WW-1:0] bld_i_q;
	logic [3:0] bstep_q;
	logic bload_q;
	logic [14:0] num_q;
	logic [7:0] rem_q;

	// Multiply-accumulate pipeline.
	logic [WW-1:0] tap_q;
	logic [WW-1:0] base_q;
	logic rd_v_s1;
	logic last_s1;
	logic [hsmb_pkg::COEF_W-1:0] coef_s1;
	logic signed [hsmb_pkg::SAMPLE_W-1:0] hist_s1;
	logic v_s2;
	logic last_s2;
	logic signed [47:0] prod_s2;
	logic signed [hsmb_pkg::ACC_W-1:0] acc_q;

	logic out_valid_q;
	logic [PW-1:0] out_start_q;
	logic [PW-1:0] out_end_q;
	logic out_final_q;

	logic [hsmb_pkg::COEF_W-1:0] coef_mem [hsmb_pkg::HIST_DEPTH];
	logic signed [hsmb_pkg::SAMPLE_W-1:0] hist_mem [hsmb_pkg::HIST_DEPTH];

	logic cfg_wr;
	logic accept;
	logic slot_free;
	logic [WW-1:0] margin;
	logic [WW-1:0] win_m1;
	logic issue;
	logic [7:0] div_sh;
	logic div_ge;
	logic [7:0] div_den;
	logic coef_we;
	logic signed [48:0] prod_full;
	logic signed [hsmb_pkg::ACC_W-1:0] acc_sum;
	logic signed [hsmb_pkg::ACC_W-1:0] acc_shr;
	logic push_cond;
	logic push_emit;
	logic out_load;
	logic [PW-1:0] flush_done;
	logic [PW-1:0] pos_next;
	logic [PW-1:0] margin_p;
	logic [WW-1:0] cfg_eff;

	assign pready = 1'b1;
	assign prdata = {26'd0, cfg_q};
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign cfg_eff = hsmb_pkg::eff_window(pwdata[WW-1:0]);

	assign samples.ready = (state_q == ST_IDLE);
	assign accept = samples.valid && (state_q == ST_IDLE);

	assign blocks.valid = out_valid_q;
	assign blocks.block_start = out_start_q;
	assign blocks.block_end = out_end_q;
	assign blocks.final_block = out_final_q;
	assign slot_free = !out_valid_q || blocks.ready;

	assign margin = win_q >> 1;
	assign margin_p = PW'(margin);
	assign win_m1 = win_q - WW'(1);

	// Restoring divider step for the cosine index of one tap.
	assign div_den = {1'b0, win_m1, 1'b0};
	assign div_sh = {rem_q[6:0], num_q[14]};
	assign div_ge = (div_sh >= div_den);
	assign coef_we = (state_q == ST_BUILD) && !bload_q && (bstep_q == 4'd15);

	assign issue = (state_q == ST_MAC) && (tap_q < win_q);
	assign prod_full = $signed({1'b0, coef_s1}) * hist_s1;
	assign acc_sum = acc_q + hsmb_pkg::ACC_W'(prod_s2);
	assign acc_shr = acc_sum >>> 15;

	assign push_cond = (pos_q >= PW'(2)) && (prev_q < prev2_q) && (prev_q < val_q);
	assign push_emit = push_cond && (nres_q < 2'(hsmb_pkg::MAX_MINIMA));
	assign out_load = !cfg_wr && slot_free &&
		(((state_q == ST_PUSH) && push_emit) || (state_q == ST_CLOSE));
	assign pos_next = pos_q + PW'(1);
	assign flush_done = (count_q > margin_p) ? (count_q - margin_p) : '0;

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[bld_i_q] <= hsmb_pkg::hann_coef(num_q[7:0]);
		end
		coef_s1 <= coef_mem[tap_q];
	end

	always_ff @(posedge clk) begin
		if (accept && (count_q < hsmb_pkg::MAX_LENGTH_P)) begin
			hist_mem[count_q[WW-1:0]] <= samples.sample;
		end
		hist_s1 <= hist_mem[base_q + tap_q];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_full[47:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			last_s1 <= 1'b0;
			v_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			last_s1 <= issue && (tap_q == win_m1);
			v_s2 <= rd_v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BUILD;
			cfg_q <= WW'(3);
			win_q <= WW'(3);
			count_q <= '0;
			seg_start_q <= '0;
			pos_q <= '0;
			prev_q <= '0;
			prev2_q <= '0;
			val_q <= '0;
			nres_q <= '0;
			fin_q <= 1'b0;
			flush_q <= 1'b0;
			bld_i_q <= '0;
			bstep_q <= '0;
			bload_q <= 1'b1;
			num_q <= '0;
			rem_q <= '0;
			tap_q <= '0;
			base_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			out_start_q <= '0;
			out_end_q <= '0;
			out_final_q <= 1'b0;
		end else begin
			if (blocks.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				cfg_q <= pwdata[WW-1:0];
				win_q <= cfg_eff;
				count_q <= '0;
				seg_start_q <= '0;
				prev_q <= '0;
				prev2_q <= '0;
				bld_i_q <= '0;
				bload_q <= 1'b1;
				state_q <= ST_BUILD;
			end else begin
				case (state_q)
					ST_BUILD: begin
						if (bload_q) begin
							num_q <= {bld_i_q, 9'd0} + 15'(win_m1);
							rem_q <= '0;
							bstep_q <= '0;
							bload_q <= 1'b0;
						end else if (bstep_q != 4'd15) begin
							rem_q <= div_ge ? (div_sh - div_den) : div_sh;
							num_q <= {num_q[13:0], div_ge};
							bstep_q <= bstep_q + 4'd1;
						end else if (bld_i_q == win_m1) begin
							state_q <= ST_IDLE;
						end else begin
							bld_i_q <= bld_i_q + WW'(1);
							bload_q <= 1'b1;
						end
					end
					ST_IDLE: begin
						if (accept) begin
							nres_q <= '0;
							fin_q <= samples.is_final;
							flush_q <= 1'b0;
							tap_q <= '0;
							acc_q <= '0;
							base_q <= count_q[WW-1:0] - win_m1;
							if (count_q < hsmb_pkg::MAX_LENGTH_P) begin
								count_q <= count_q + PW'(1);
								if (count_q >= margin_p) begin
									pos_q <= count_q - margin_p;
									if (count_q >= PW'(win_m1)) begin
										state_q <= ST_MAC;
									end else begin
										val_q <= '0;
										state_q <= ST_PUSH;
									end
								end else begin
									state_q <= samples.is_final ? ST_FLUSH : ST_IDLE;
								end
							end else begin
								state_q <= samples.is_final ? ST_FLUSH : ST_IDLE;
							end
						end
					end
					ST_MAC: begin
						if (issue) begin
							tap_q <= tap_q + WW'(1);
						end
						if (v_s2) begin
							acc_q <= acc_sum;
							if (last_s2) begin
								val_q <= acc_shr[SW-1:0];
								state_q <= ST_PUSH;
							end
						end
					end
					ST_PUSH: begin
						if (!push_emit || slot_free) begin
							if (push_emit) begin
								out_valid_q <= 1'b1;
								out_start_q <= seg_start_q;
								out_end_q <= pos_q - PW'(1);
								out_final_q <= 1'b0;
								nres_q <= nres_q + 2'd1;
							end
							if (push_cond) begin
								seg_start_q <= pos_q;
							end
							prev2_q <= prev_q;
							prev_q <= val_q;
							if (flush_q) begin
								if (pos_next < count_q) begin
									pos_q <= pos_next;
								end else begin
									state_q <= ST_CLOSE;
								end
							end else begin
								state_q <= fin_q ? ST_FLUSH : ST_IDLE;
							end
						end
					end
					ST_FLUSH: begin
						if (flush_done < count_q) begin
							pos_q <= flush_done;
							val_q <= '0;
							flush_q <= 1'b1;
							state_q <= ST_PUSH;
						end else begin
							state_q <= ST_CLOSE;
						end
					end
					ST_CLOSE: begin
						if (slot_free) begin
							out_valid_q <= 1'b1;
							out_start_q <= seg_start_q;
							out_end_q <= count_q;
							out_final_q <= 1'b1;
							count_q <= '0;
							seg_start_q <= '0;
							prev_q <= '0;
							prev2_q <= '0;
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

// File: tb/hsmb_checker.sv
// Watches the sample, block and APB channels, predicts segments and compares them.
module hsmb_checker
	import hsmb_pkg::*;
#(
	parameter logic [2:0] WINDOW_REG_ADDR = 3'd0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic pready,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	hsmb_sample_if samples,
	hsmb_block_if blocks,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEG_LIMIT = 4;

	typedef struct packed {
		logic [POS_W-1:0] first;
		logic [POS_W-1:0] last;
		logic closing;
	} segment_t;

	segment_t segment_q[$];

	int win_len;
	logic [COEF_W-1:0] hann[HIST_DEPTH];
	longint history[HIST_DEPTH];
	longint smooth_last;
	longint smooth_last2;
	int seq_len;
	int seg_first;
	int seg_made;

	function automatic longint quarter_wave(longint unsigned u);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint acc;
		x = (64'd1686629713 * u) / 64'd256;
		x2 = (x * x) >> 30;
		term = 64'd1073741824;
		acc = 64'sd1073741824;
		for (int k = 1; k <= 7; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				acc -= longint'(term);
			end else begin
				acc += longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > 64'sd1073741824) begin
			acc = 64'sd1073741824;
		end
		return (acc + 16384) >>> 15;
	endfunction

	function automatic longint cosine_q15(int j);
		int a;
		int quad;
		int r;
		a = 4 * j;
		quad = (a / COS_TABLE_DEPTH) & 3;
		r = a % COS_TABLE_DEPTH;
		case (quad)
			0: return quarter_wave(r);
			1: return -quarter_wave(COS_TABLE_DEPTH - r);
			2: return -quarter_wave(r);
			default: return quarter_wave(COS_TABLE_DEPTH - r);
		endcase
	endfunction

	task automatic restart_sequence();
		foreach (history[i]) begin
			history[i] = 0;
		end
		smooth_last = 0;
		smooth_last2 = 0;
		seq_len = 0;
		seg_first = 0;
	endtask

	task automatic load_window(logic [WIN_W-1:0] wl);
		int w;
		int j;
		w = int'(wl);
		if (w % 2 == 0 && w != 0) begin
			w -= 1;
		end
		if (w < 3) begin
			w = 3;
		end
		win_len = w;
		for (int i = 0; i < w; i++) begin
			j = (2 * i * COS_TABLE_DEPTH + (w - 1)) / (2 * (w - 1));
			if (j >= COS_TABLE_DEPTH) begin
				j -= COS_TABLE_DEPTH;
			end
			hann[i] = COEF_W'((32768 - cosine_q15(j) + 1) >>> 1);
		end
		restart_sequence();
	endtask

	task automatic add_segment(int first, int last, logic closing);
		segment_t s;
		if (seg_made >= SEG_LIMIT) begin
			return;
		end
		s.first = POS_W'(first);
		s.last = POS_W'(last);
		s.closing = closing;
		segment_q.insert(segment_q.size(), s);
		seg_made++;
	endtask

	// A minimum at position c-1 is seen once the value at c is known.
	task automatic take_position(int c, longint val);
		if (c >= 2 && smooth_last < smooth_last2 && smooth_last < val) begin
			if (seg_made < SEG_LIMIT - 1) begin
				add_segment(seg_first, c - 1, 1'b0);
			end
			seg_first = c;
		end
		smooth_last2 = smooth_last;
		smooth_last = val;
	endtask

	function automatic longint smoothed_at(int k);
		longint acc;
		int base;
		acc = 0;
		base = k - (win_len - 1);
		for (int i = 0; i < win_len; i++) begin
			acc += longint'(hann[i]) * history[(base + i) & (HIST_DEPTH - 1)];
		end
		return acc >>> 15;
	endfunction

	task automatic predict_sample(logic signed [31:0] x, logic fin);
		int margin;
		int k;
		int done;
		longint v;
		margin = win_len / 2;
		seg_made = 0;
		if (seq_len < MAX_LENGTH) begin
			k = seq_len;
			history[k & (HIST_DEPTH - 1)] = longint'(x);
			seq_len = k + 1;
			if (k >= margin) begin
				v = (k >= 2 * margin) ? smoothed_at(k) : 0;
				take_position(k - margin, v);
			end
		end
		if (fin) begin
			done = (seq_len > margin) ? seq_len - margin : 0;
			for (int c = done; c < seq_len; c++) begin
				take_position(c, 0);
			end
			add_segment(seg_first, seq_len, 1'b1);
			restart_sequence();
		end
	endtask

	task automatic report(string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		segment_t got;
		segment_t want;
		if (!arst_n) begin
			segment_q.delete();
			load_window(WIN_W'(3));
			errors <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == WINDOW_REG_ADDR) begin
				load_window(pwdata[WIN_W-1:0]);
			end
			if (samples.valid && samples.ready) begin
				predict_sample(samples.sample, samples.is_final);
			end
			if (blocks.valid && blocks.ready) begin
				got.first = blocks.block_start;
				got.last = blocks.block_end;
				got.closing = blocks.final_block;
				if (segment_q.size() == 0) begin
					report($sformatf("unexpected segment %0d..%0d final %0b",
						got.first, got.last, got.closing));
				end else begin
					want = segment_q.pop_front();
					if (got.first != want.first) begin
						report($sformatf("block_start %0d, predicted %0d", got.first, want.first));
					end
					if (got.last != want.last) begin
						report($sformatf("block_end %0d, predicted %0d", got.last, want.last));
					end
					if (got.closing != want.closing) begin
						report($sformatf("final_block %0b, predicted %0b",
							got.closing, want.closing));
					end
				end
			end
			pending <= segment_q.size();
		end
	end

endmodule

// File: tb/tb.sv
// Top of the testbench: clock, reset, stimulus on all ports and the verdict.
module tb;
	import hsmb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] WINDOW_REG_ADDR = 3'd0;
	localparam int SETTLE_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int errors;
	int pending;
	logic hold_request;
	int sent;

	hsmb_sample_if smp ();
	hsmb_block_if blk ();

	hann_smoothing_minima_blocker DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.samples(smp),
		.blocks(blk)
	);

	hsmb_checker #(.WINDOW_REG_ADDR(WINDOW_REG_ADDR)) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.samples(smp),
		.blocks(blk),
		.errors(errors),
		.pending(pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic int gap_length();
		if ($urandom_range(0, 3) == 0) begin
			return 0;
		end
		return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	// Receiver side: random stalls, plus one long hold-off on request.
	initial begin
		blk.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				blk.ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_request = 1'b0;
			end
			blk.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if ($urandom_range(0, 2) != 0) begin
				blk.ready <= 1'b0;
				repeat (gap_length() + 1) @(posedge clk);
			end
		end
	end

	task automatic send_sample(logic signed [31:0] x, logic fin);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid <= 1'b1;
		smp.sample <= x;
		smp.is_final <= fin;
		do @(posedge clk); while (!(smp.valid && smp.ready));
		sent++;
	endtask

	task automatic wait_quiet();
		smp.valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window(logic [31:0] value);
		wait_quiet();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WINDOW_REG_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] random_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6, 7: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 10;
			8: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			default: return 32'h8000_0000 + $urandom_range(0, 3);
		endcase
	endfunction

	task automatic random_sequence(int len, bit close);
		for (int i = 0; i < len; i++) begin
			send_sample(random_sample(), close && i == len - 1);
		end
	endtask

	initial begin
		int settings[8];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 1'b0;
		smp.sample = '0;
		smp.is_final = 1'b0;
		hold_request = 1'b0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a lone final sample, a short closing sequence, extreme values
		// and a sequence with clear minima at the reset window.
		send_sample(32'sh7FFF_FFFF, 1'b1);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh8000_0000, 1'b1);
		send_sample(32'sh0001_0000, 1'b0);
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh0000_0000, 1'b0);
		send_sample(32'sh8000_0000, 1'b0);
		send_sample(32'sh7FFF_FFFF, 1'b0);
		send_sample(32'sh8000_0000, 1'b1);
		// A write in the middle of a sequence restarts it.
		send_sample(32'sh0005_0000, 1'b0);
		send_sample(32'sh0001_0000, 1'b0);
		write_window(32'hFFFF_FFC0);
		random_sequence(3, 1'b1);
		write_window(32'd63);
		// Sequence shorter than the window closes with only one segment.
		random_sequence(6, 1'b1);

		settings = '{1, 2, 62, 5, 9, 4, 63, 3};
		hold_request = 1'b1;
		for (int p = 0; p < 12; p++) begin
			if (p < 8) begin
				write_window(settings[p]);
			end else begin
				write_window($urandom);
			end
			// The first sequence runs under the long hold-off, so the block fills up.
			if (p == 0) begin
				random_sequence(40, 1'b1);
			end else begin
				random_sequence($urandom_range(1, 6), $urandom_range(0, 5) != 0);
			end
		end

		smp.valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
